// ----- hw/rtl/ket_pkg.sv -----
// ----------------------------------------------------------------------------
// ket_pkg
// Shared types, widths and codes of the key expiry table.
// ----------------------------------------------------------------------------
package ket_pkg;

  localparam int unsigned KEY_W  = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned ST_W   = 4;
  localparam int unsigned REQ_W  = 3;

  localparam logic [REQ_W-1:0] REQ_SET   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd1;
  localparam logic [REQ_W-1:0] REQ_GET   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SWEEP = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COUNT = 3'd4;

  localparam logic [ST_W-1:0] ST_INSERTED  = 4'd0;
  localparam logic [ST_W-1:0] ST_UPDATED   = 4'd1;
  localparam logic [ST_W-1:0] ST_REMOVED   = 4'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 4'd3;
  localparam logic [ST_W-1:0] ST_FOUND     = 4'd4;
  localparam logic [ST_W-1:0] ST_FULL      = 4'd5;
  localparam logic [ST_W-1:0] ST_BAD_LEN   = 4'd6;
  localparam logic [ST_W-1:0] ST_EXPIRED   = 4'd7;
  localparam logic [ST_W-1:0] ST_NONE_EXP  = 4'd8;
  localparam logic [ST_W-1:0] ST_COUNT     = 4'd9;

  // Classified operation handed from the front to the engine.
  typedef enum logic [2:0] {
    OP_SET,
    OP_BADLEN,
    OP_CLEAR,
    OP_GET,
    OP_SWEEP,
    OP_COUNT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [LEN_W-1:0]  len;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] exp;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [TIME_W-1:0] time_out;
    logic [CNT_W-1:0]  count_out;
    logic [KEY_W-1:0]  key_out;
    logic [LEN_W-1:0]  key_len_out;
    logic              last;
  } rsp_t;

  // Keeps the bytes of a key below its length.
  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      m[8*b +: 8] = (len > LEN_W'(b)) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ----- hw/rtl/ket_req_if.sv -----
// ----------------------------------------------------------------------------
// ket_req_if
// Request channel of the key expiry table.
// ----------------------------------------------------------------------------
interface ket_req_if;
  logic                       valid;
  logic                       ready;
  logic [ket_pkg::REQ_W-1:0]  req_type;
  logic [ket_pkg::LEN_W-1:0]  key_len;
  logic [ket_pkg::KEY_W-1:0]  key_bytes;
  logic [ket_pkg::TIME_W-1:0] expire_time;
  logic [ket_pkg::TIME_W-1:0] now_time;

  modport source (
    output valid, req_type, key_len, key_bytes, expire_time, now_time,
    input  ready
  );
  modport sink (
    input  valid, req_type, key_len, key_bytes, expire_time, now_time,
    output ready
  );
endinterface

// ----- hw/rtl/ket_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ket_rsp_if
// Result channel of the key expiry table.
// ----------------------------------------------------------------------------
interface ket_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ket_pkg::ST_W-1:0]   status;
  logic [ket_pkg::TIME_W-1:0] time_out;
  logic [ket_pkg::CNT_W-1:0]  count_out;
  logic [ket_pkg::KEY_W-1:0]  key_out;
  logic [ket_pkg::LEN_W-1:0]  key_len_out;
  logic                       last;

  modport source (
    output valid, status, time_out, count_out, key_out, key_len_out, last,
    input  ready
  );
  modport sink (
    input  valid, status, time_out, count_out, key_out, key_len_out, last,
    output ready
  );
endinterface

// ----- hw/rtl/ket_front.sv -----
// ----------------------------------------------------------------------------
// ket_front
// Accepts requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module ket_front #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ket_req_if.sink       req_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output ket_pkg::cmd_t cmd_o
);
  import ket_pkg::*;

  cmd_t       cls;
  logic       known;
  logic       push;
  logic       pop;
  cmd_t       q_mem [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  // Unknown request types are taken and dropped.
  always_comb begin
    known   = 1'b1;
    cls.len = req_i.key_len;
    cls.key = req_i.key_bytes & key_mask(req_i.key_len);
    cls.exp = req_i.expire_time;
    cls.now = req_i.now_time;
    cls.op  = OP_GET;
    case (req_i.req_type)
      REQ_SET: begin
        if (req_i.key_len == '0 || req_i.key_len > LEN_W'(KEY_BYTES)) begin
          cls.op = OP_BADLEN;
        end else begin
          cls.op = OP_SET;
        end
      end
      REQ_CLEAR: cls.op = OP_CLEAR;
      REQ_GET:   cls.op = OP_GET;
      REQ_SWEEP: cls.op = OP_SWEEP;
      REQ_COUNT: cls.op = OP_COUNT;
      default:   known  = 1'b0;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready && known;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = q_mem[rp_q];
  assign cnt_d       = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wp_q] <= cls;
  end

endmodule

// ----- hw/rtl/ket_engine.sv -----
// ----------------------------------------------------------------------------
// ket_engine
// Walks the slot memory for each queued request but a bad-length set and emits result beats.
// ----------------------------------------------------------------------------
module ket_engine #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  ket_pkg::cmd_t cmd_i,
  ket_rsp_if.source     rsp_o
);
  import ket_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = 8 * KEY_BYTES;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_CHK, S_MVRD, S_MVWR, S_END} state_e;

  typedef struct packed {
    logic [KW-1:0]     key;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] exp;
  } ent_t;

  ent_t              mem_q [TABLE_DEPTH];
  ent_t              rdata_q;
  logic [AW-1:0]     raddr, waddr;
  logic              we;
  ent_t              wdata;

  state_e            st_q, st_d;
  cmd_t              cmd_q, cmd_d;
  logic [CW-1:0]     idx_q, idx_d, used_q, used_d, n_q, n_d, used_m1;
  logic              hit_q, hit_d;
  logic              pend_v_q, pend_v_d;
  rsp_t              pend_q, pend_d;
  logic              out_v_q, out_v_d;
  rsp_t              out_q, out_d;
  logic              emit;
  rsp_t              emit_rsp;
  logic              can_emit, match, expired;

  assign can_emit = !out_v_q || rsp_o.ready;
  assign used_m1  = used_q - 1'b1;
  assign match    = (rdata_q.len == cmd_q.len) && (rdata_q.key == cmd_q.key[KW-1:0]);
  assign expired  = (rdata_q.exp != '0) && (rdata_q.exp <= cmd_q.now);

  always_comb begin
    st_d        = st_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    used_d      = used_q;
    n_d         = n_q;
    hit_d       = hit_q;
    pend_v_d    = pend_v_q;
    pend_d      = pend_q;
    raddr       = idx_q[AW-1:0];
    we          = 1'b0;
    waddr       = idx_q[AW-1:0];
    wdata       = rdata_q;
    emit        = 1'b0;
    emit_rsp    = '0;
    emit_rsp.count_out = CNT_W'(used_q);
    emit_rsp.last      = 1'b1;
    cmd_ready_o = 1'b0;

    case (st_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          idx_d = '0;
          n_d   = '0;
          hit_d = 1'b0;
          st_d  = (cmd_i.op == OP_BADLEN) ? S_END : S_SCAN;
        end
      end
      S_SCAN: begin
        st_d = (idx_q >= used_q) ? S_END : S_CHK;
      end
      S_CHK: begin
        case (cmd_q.op)
          OP_SET: begin
            if (match) begin
              if (can_emit) begin
                we              = 1'b1;
                wdata.exp       = cmd_q.exp;
                emit            = 1'b1;
                emit_rsp.status = ST_UPDATED;
                st_d            = S_IDLE;
              end
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = S_SCAN;
            end
          end
          OP_CLEAR: begin
            if (match) begin
              hit_d = 1'b1;
              st_d  = S_MVRD;
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = S_SCAN;
            end
          end
          OP_GET: begin
            if (match) begin
              if (can_emit) begin
                emit              = 1'b1;
                emit_rsp.status   = ST_FOUND;
                emit_rsp.time_out = rdata_q.exp;
                st_d              = S_IDLE;
              end
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = S_SCAN;
            end
          end
          OP_COUNT: begin
            if (!expired) n_d = n_q + 1'b1;
            idx_d = idx_q + 1'b1;
            st_d  = S_SCAN;
          end
          OP_SWEEP: begin
            if (expired) begin
              if (!pend_v_q || can_emit) begin
                if (pend_v_q) begin
                  emit     = 1'b1;
                  emit_rsp = pend_q;
                end
                pend_v_d             = 1'b1;
                pend_d               = '0;
                pend_d.status        = ST_EXPIRED;
                pend_d.count_out     = CNT_W'(n_q + 1'b1);
                pend_d.key_out       = KEY_W'(rdata_q.key);
                pend_d.key_len_out   = rdata_q.len;
                n_d                  = n_q + 1'b1;
                st_d                 = S_MVRD;
              end
            end else begin
              idx_d = idx_q + 1'b1;
              st_d  = S_SCAN;
            end
          end
          default: st_d = S_IDLE;
        endcase
      end
      S_MVRD: begin
        raddr = used_m1[AW-1:0];
        st_d  = S_MVWR;
      end
      S_MVWR: begin
        // The last entry fills the hole; harmless when the hole is the last.
        we     = 1'b1;
        used_d = used_m1;
        st_d   = (cmd_q.op == OP_SWEEP) ? S_SCAN : S_END;
      end
      S_END: begin
        if (can_emit) begin
          emit = 1'b1;
          st_d = S_IDLE;
          case (cmd_q.op)
            OP_SET: begin
              if (used_q == CW'(TABLE_DEPTH)) begin
                emit_rsp.status = ST_FULL;
              end else begin
                we                 = 1'b1;
                waddr              = used_q[AW-1:0];
                wdata.key          = cmd_q.key[KW-1:0];
                wdata.len          = cmd_q.len;
                wdata.exp          = cmd_q.exp;
                used_d             = used_q + 1'b1;
                emit_rsp.status    = ST_INSERTED;
                emit_rsp.count_out = CNT_W'(used_q + 1'b1);
              end
            end
            OP_BADLEN: emit_rsp.status = ST_BAD_LEN;
            OP_CLEAR:  emit_rsp.status = hit_q ? ST_REMOVED : ST_NOT_FOUND;
            OP_GET:    emit_rsp.status = ST_NOT_FOUND;
            OP_COUNT: begin
              emit_rsp.status    = ST_COUNT;
              emit_rsp.count_out = CNT_W'(n_q);
            end
            OP_SWEEP: begin
              if (pend_v_q) begin
                emit_rsp      = pend_q;
                emit_rsp.last = 1'b1;
                pend_v_d      = 1'b0;
              end else begin
                emit_rsp.status    = ST_NONE_EXP;
                emit_rsp.count_out = '0;
              end
            end
            default: emit = 1'b0;
          endcase
        end
      end
      default: st_d = S_IDLE;
    endcase

    out_v_d = out_v_q && !rsp_o.ready;
    out_d   = out_q;
    if (emit) begin
      out_v_d = 1'b1;
      out_d   = emit_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      used_q   <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q     <= st_d;
      used_q   <= used_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    n_q    <= n_d;
    hit_q  <= hit_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  assign rsp_o.valid       = out_v_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.time_out    = out_q.time_out;
  assign rsp_o.count_out   = out_q.count_out;
  assign rsp_o.key_out     = out_q.key_out;
  assign rsp_o.key_len_out = out_q.key_len_out;
  assign rsp_o.last        = out_q.last;

  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(TABLE_DEPTH))
    else $error("slot count above table depth");

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_IDLE |-> !pend_v_q)
    else $error("sweep result left pending after request");

  a_move_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_MVWR |-> used_q != '0)
    else $error("entry move on empty table");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_END && can_emit && cmd_q.op == OP_SET && used_q != CW'(TABLE_DEPTH))
    |=> used_q == $past(used_q) + 1'b1)
    else $error("insert did not grow the table");

endmodule

// ----- hw/rtl/key_expiry_table.sv -----
// ----------------------------------------------------------------------------
// key_expiry_table
// Table of short keys with 32-bit expiry times: set, clear, get, sweep, count.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Beat contents                                      Beats/req
//   req_i    in   req_type, key_len, key_bytes, expire_time, now_time  1
//   rsp_o    out  status, time_out, count_out, key_out, key_len_out,   1, or one
//                 last                                                 per expired
//                                                                      key on sweep
//
// A request walks the occupied slots one at a time through a slot memory
// with one read port, one write port and a registered read. A clear, and a
// sweep for each removed key, moves the last entry into the hole it leaves.
// Reset clears the state, the slot count and the valid flags but not the
// slots, so no clearing pass is needed: slots at or above the count are
// never examined. A two-beat queue parts the front from the engine and a
// result register parts the engine from the sink, so the front keeps
// taking requests, while its queue has room, when a result beat stalls.
//
module key_expiry_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ket_req_if.sink  req_i,
  ket_rsp_if.source rsp_o
);
  import ket_pkg::*;

  // Classified request beat between the front and the engine.
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // The front checks the key length of a set and drops unknown request
  // types, so the engine only ever sees meaningful operations.
  ket_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // The engine owns the slot memory and the slot count, and emits every
  // result beat, holding back each sweep beat until it knows whether it is
  // the final one.
  ket_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .rsp_o       (rsp_o)
  );

endmodule
